/* rtl/klpt_pkg.sv */
package klpt_pkg;

  // fixed field widths
  localparam int KEY_BITMAP_W = 16;
  localparam int TIME_W       = 32;
  localparam int KEY_INDEX_W  = 4;

  // threshold after reset, in ms
  localparam logic [TIME_W-1:0] THRESH_RESET = 32'd1000;

  // per-key phase
  typedef enum logic [1:0] {
    PH_RELEASED = 2'd0,
    PH_PRESSED  = 2'd1,
    PH_LONG     = 2'd2
  } phase_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // latch a new poll word, restart the scan
    logic scan;   // evaluate the current key and advance
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;    // current key is reported
    logic last;   // current key is the last one
  } stat_t;

endpackage

/* rtl/klpt_if.sv */
// poll channel
interface klpt_in_if;
  import klpt_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [KEY_BITMAP_W-1:0] key_bitmap;
  logic [TIME_W-1:0]       now_ms;
  modport source (output valid, output key_bitmap, output now_ms, input ready);
  modport sink   (input valid, input key_bitmap, input now_ms, output ready);
endinterface

// result channel
interface klpt_out_if;
  import klpt_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   key_found;
  logic [KEY_INDEX_W-1:0] key_index;
  modport source (output valid, output key_found, output key_index, input ready);
  modport sink   (input valid, input key_found, input key_index, output ready);
endinterface

// threshold write channel
interface klpt_cfg_if;
  import klpt_pkg::*;
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] long_press_threshold_ms;
  modport source (output valid, output long_press_threshold_ms, input ready);
  modport sink   (input valid, input long_press_threshold_ms, output ready);
endinterface

/* rtl/klpt_ctrl.sv */
module klpt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  klpt_pkg::stat_t stat,
  output klpt_pkg::cmd_t  cmd
);
  import klpt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_OUT
  } state_t;

  state_t state_r;
  logic   in_ready_r;
  logic   out_valid_r;

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

  // commands
  always_comb begin
    cmd.load = in_ready_r && in_valid;
    cmd.scan = (state_r == S_SCAN);
  end

  // state and registered handshake outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r    <= S_SCAN;
            in_ready_r <= 1'b0;
          end
        end
        S_SCAN: begin
          // stop at the first reported key or after the last key
          if (stat.hit || stat.last) begin
            state_r     <= S_OUT;
            out_valid_r <= 1'b1;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b0;
            in_ready_r  <= 1'b1;
          end
        end
        default: begin
          state_r     <= S_IDLE;
          in_ready_r  <= 1'b1;
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

endmodule

/* rtl/klpt_dp.sv */
module klpt_dp #(
  parameter int NUM_KEYS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  klpt_pkg::cmd_t                    cmd,
  output klpt_pkg::stat_t                   stat,
  input  logic [klpt_pkg::KEY_BITMAP_W-1:0] key_bitmap,
  input  logic [klpt_pkg::TIME_W-1:0]       now_ms,
  input  logic                              cfg_we,
  input  logic [klpt_pkg::TIME_W-1:0]       cfg_data,
  output logic                              key_found,
  output logic [klpt_pkg::KEY_INDEX_W-1:0]  key_index
);
  import klpt_pkg::*;

  localparam int IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  logic [TIME_W-1:0]       thresh_r;
  logic [KEY_BITMAP_W-1:0] bitmap_r;
  logic [TIME_W-1:0]       now_r;
  logic [IDX_W-1:0]        idx_r;
  logic                    found_r;
  logic [IDX_W-1:0]        res_idx_r;
  phase_t                  phase_r [NUM_KEYS];
  logic [TIME_W-1:0]       start_r [NUM_KEYS];

  logic [NUM_KEYS-1:0]     down_all;
  logic                    down;
  phase_t                  ph;
  logic [TIME_W-1:0]       start_cur;
  logic [TIME_W-1:0]       elapsed;
  phase_t                  phase_nxt;
  logic [TIME_W-1:0]       start_nxt;
  logic                    hit;
  logic [31:0]             res_wide;

  // keys beyond the bitmap are always up
  generate
    if (NUM_KEYS <= KEY_BITMAP_W) begin : g_narrow
      assign down_all = bitmap_r[NUM_KEYS-1:0];
    end else begin : g_wide
      assign down_all = {{(NUM_KEYS-KEY_BITMAP_W){1'b0}}, bitmap_r};
    end
  endgenerate

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RESET;
    end else if (cfg_we) begin
      thresh_r <= cfg_data;
    end
  end

  // evaluate the key under the scan index
  always_comb begin
    down      = down_all[idx_r];
    ph        = phase_r[idx_r];
    start_cur = start_r[idx_r];
    elapsed   = now_r - start_cur;
    phase_nxt = ph;
    start_nxt = start_cur;
    hit       = 1'b0;
    if (down) begin
      case (ph)
        PH_RELEASED: begin
          phase_nxt = PH_PRESSED;
          start_nxt = now_r;
          hit       = 1'b1;
        end
        PH_PRESSED: begin
          if (elapsed >= thresh_r) begin
            phase_nxt = PH_LONG;
            hit       = 1'b1;
          end
        end
        PH_LONG: begin
          hit = 1'b1;
        end
        default: begin
          // unused code: not reported, state kept
          phase_nxt = ph;
        end
      endcase
    end else begin
      phase_nxt = PH_RELEASED;
      start_nxt = '0;
    end
  end

  always_comb begin
    stat.hit  = hit;
    stat.last = (idx_r == IDX_W'(NUM_KEYS - 1));
  end

  // scan index and result; the poll word is latched in the block below
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      found_r   <= 1'b0;
      res_idx_r <= '0;
    end else if (cmd.load) begin
      idx_r     <= '0;
      found_r   <= 1'b0;
      res_idx_r <= '0;
    end else if (cmd.scan) begin
      idx_r <= idx_r + 1'b1;
      if (hit) begin
        found_r   <= 1'b1;
        res_idx_r <= idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bitmap_r <= key_bitmap;
      now_r    <= now_ms;
    end
  end

  // key phases
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        phase_r[k] <= PH_RELEASED;
      end
    end else if (cmd.scan) begin
      phase_r[idx_r] <= phase_nxt;
    end
  end

  // press start ticks, only read while a key is pressed
  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      start_r[idx_r] <= start_nxt;
    end
  end

  assign res_wide  = 32'(res_idx_r);
  assign key_found = found_r;
  assign key_index = res_wide[KEY_INDEX_W-1:0];

endmodule

/* rtl/keypad_long_press_tracker_core.sv */
// Sequence: accept a poll word in the idle state, then scan the keys in order up to
// and including the first reported key (all keys when none is reported), then offer
// the result word. A new poll is accepted only after the result word is taken; the
// scan visits one key per cycle through a single evaluate unit.
// Reset: synchronous, active low; all keys released, threshold 1000 ms.
module keypad_long_press_tracker_core #(
  parameter int NUM_KEYS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  klpt_in_if.sink    in_ch,
  klpt_out_if.source out_ch,
  klpt_cfg_if.sink   cfg_ch
);
  import klpt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // threshold writes are always taken
  assign cfg_ch.ready = 1'b1;

  klpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  klpt_dp #(
    .NUM_KEYS (NUM_KEYS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .key_bitmap (in_ch.key_bitmap),
    .now_ms     (in_ch.now_ms),
    .cfg_we     (cfg_ch.valid),
    .cfg_data   (cfg_ch.long_press_threshold_ms),
    .key_found  (out_ch.key_found),
    .key_index  (out_ch.key_index)
  );

endmodule
